[rtl/core/fpec_pkg.sv]
package fpec_pkg;

  localparam int NPLANES = 6;
  localparam int NCOEF   = 4;
  localparam int RAW_W   = 33;
  localparam int PLN_W   = 48;
  localparam int ACC_W   = 80;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_POINT  = 2'd1,
    OP_SPHERE = 2'd2,
    OP_BOX    = 2'd3
  } op_e;

  localparam logic [1:0] LAST_COL = 2'd3;

  typedef logic [NCOEF-1:0][RAW_W-1:0] raw_vec_t;
  typedef logic [NCOEF-1:0][PLN_W-1:0] pln_vec_t;
  typedef logic [2:0][31:0]            xyz_t;

  typedef struct packed {
    logic done;
    logic deg;
  } norm_res_t;

  typedef struct packed {
    logic done;
    logic pass;
  } dot_res_t;

endpackage

[rtl/core/fpec_cell.sv]
module fpec_cell #(
  parameter int PLANE = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [1:0]        col_i,
  input  logic [31:0]       val_x_i,
  input  logic [31:0]       val_d_i,
  input  logic              shift_i,
  input  fpec_pkg::raw_vec_t raw_i,
  input  fpec_pkg::pln_vec_t pln_i,
  output fpec_pkg::raw_vec_t raw_o,
  output fpec_pkg::pln_vec_t pln_o
);

  localparam bit SUB = (PLANE % 2) == 1;

  fpec_pkg::raw_vec_t raw_q;
  fpec_pkg::pln_vec_t pln_q;
  logic signed [fpec_pkg::RAW_W-1:0] coef;

  // Even planes take row 3 plus the axis row, odd planes row 3 minus it.
  always_comb begin
    if (SUB) begin
      coef = $signed({val_d_i[31], val_d_i}) - $signed({val_x_i[31], val_x_i});
    end else begin
      coef = $signed({val_d_i[31], val_d_i}) + $signed({val_x_i[31], val_x_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q <= '0;
      pln_q <= '0;
    end else if (load_i) begin
      raw_q[col_i] <= coef;
    end else if (shift_i) begin
      raw_q <= raw_i;
      pln_q <= pln_i;
    end
  end

  assign raw_o = raw_q;
  assign pln_o = pln_q;

endmodule

[rtl/core/fpec_norm.sv]
module fpec_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  fpec_pkg::raw_vec_t raw_i,
  output fpec_pkg::pln_vec_t pln_o,
  output fpec_pkg::norm_res_t res_o
);

  typedef enum logic [5:0] {
    N_IDLE = 6'b000001,
    N_SQ   = 6'b000010,
    N_CHK  = 6'b000100,
    N_SQRT = 6'b001000,
    N_DIV  = 6'b010000,
    N_DONE = 6'b100000
  } nstate_e;

  nstate_e state_q, state_d;
  logic [3:0][32:0] m_q;
  logic [3:0]       neg_q;
  logic [6:0]       cnt_q;
  logic [61:0]      prod_q;
  logic [63:0]      s_q;
  logic [33:0]      rem_q;
  logic [31:0]      root_q;
  logic [32:0]      r_q;
  logic [32:0]      dv_q;
  logic [46:0]      qt_q;
  logic             sat_q;
  logic [1:0]       ci_q;
  logic             deg_q;
  fpec_pkg::pln_vec_t res_q;

  logic [3:0][32:0] mag;
  logic [32:0]      mx;
  logic [1:0]       sh;
  logic [35:0]      rem_n;
  logic [33:0]      trial;
  logic [33:0]      r_n;
  logic             ge;
  logic [46:0]      q_fin;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = raw_i[i][32] ? 33'(-$signed(raw_i[i])) : raw_i[i];
    end
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    sh = mx[32] ? 2'd2 : (mx[31] ? 2'd1 : 2'd0);
    rem_n = {rem_q, s_q[63:62]};
    trial = {root_q, 2'b01};
    r_n   = {r_q, (cnt_q < 7'd33) ? dv_q[32] : 1'b0};
    ge    = r_n >= {2'b00, root_q};
    q_fin = sat_q ? '1 : {qt_q[45:0], ge};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      N_IDLE:  if (start_i) state_d = N_SQ;
      N_SQ:    if (cnt_q[1:0] == 2'd3) state_d = N_CHK;
      N_CHK:   state_d = (s_q == '0) ? N_DONE : N_SQRT;
      N_SQRT:  if (cnt_q == 7'd31) state_d = N_DIV;
      N_DIV:   if (cnt_q == 7'd64 && ci_q == 2'd3) state_d = N_DONE;
      N_DONE:  state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
      ci_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        N_IDLE: begin
          cnt_q <= '0;
        end
        N_SQ: begin
          cnt_q <= (cnt_q[1:0] == 2'd3) ? 7'd0 : cnt_q + 7'd1;
        end
        N_SQRT: begin
          cnt_q <= (cnt_q == 7'd31) ? 7'd0 : cnt_q + 7'd1;
          ci_q  <= '0;
        end
        N_DIV: begin
          if (cnt_q == 7'd64) begin
            cnt_q <= '0;
            ci_q  <= ci_q + 2'd1;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        default: cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 4; i++) begin
            m_q[i]   <= mag[i] >> sh;
            neg_q[i] <= raw_i[i][32];
          end
          s_q <= '0;
        end
      end
      N_SQ: begin
        if (cnt_q[1:0] != 2'd3) begin
          prod_q <= m_q[cnt_q[1:0]][30:0] * m_q[cnt_q[1:0]][30:0];
        end
        if (cnt_q[1:0] != 2'd0) begin
          s_q <= s_q + 64'(prod_q);
        end
      end
      N_CHK: begin
        deg_q  <= (s_q == '0);
        res_q  <= '0;
        rem_q  <= '0;
        root_q <= '0;
      end
      N_SQRT: begin
        if (rem_n >= 36'(trial)) begin
          rem_q  <= 34'(rem_n - 36'(trial));
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_n[33:0];
          root_q <= {root_q[30:0], 1'b0};
        end
        s_q  <= s_q << 2;
        r_q  <= '0;
        dv_q <= m_q[0];
        qt_q <= '0;
        sat_q <= 1'b0;
      end
      N_DIV: begin
        if (cnt_q == 7'd64) begin
          res_q[ci_q] <= neg_q[ci_q] ? 48'(-$signed({1'b0, q_fin})) : {1'b0, q_fin};
          r_q   <= '0;
          dv_q  <= m_q[ci_q + 2'd1];
          qt_q  <= '0;
          sat_q <= 1'b0;
        end else begin
          r_q  <= ge ? 33'(r_n - {2'b00, root_q}) : r_n[32:0];
          dv_q <= dv_q << 1;
          qt_q <= {qt_q[45:0], ge};
          // Quotient bits at weight 2^47 and above mean the value saturates.
          if (ge && cnt_q < 7'd18) sat_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign pln_o      = res_q;
  assign res_o.done = (state_q == N_DONE);
  assign res_o.deg  = deg_q;

endmodule

[rtl/core/fpec_dot.sv]
module fpec_dot #(
  parameter int FRAC = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [1:0]         op_i,
  input  fpec_pkg::pln_vec_t pln_i,
  input  fpec_pkg::xyz_t     lo_i,
  input  fpec_pkg::xyz_t     hi_i,
  input  logic signed [fpec_pkg::ACC_W-1:0] limit_i,
  output fpec_pkg::dot_res_t res_o
);

  logic        busy_q;
  logic [3:0]  cnt_q;
  logic signed [fpec_pkg::ACC_W-1:0] acc_q;
  logic [55:0] prod_q;
  logic [78:0] t_q;
  logic        pass_q;
  logic        done_q;

  logic [1:0]  axis;
  logic signed [47:0] n;
  logic signed [31:0] pt;
  logic [46:0] nm;
  logic [31:0] pm;
  logic        neg;
  logic [23:0] mul_a;
  logic [78:0] tsh;

  always_comb begin
    axis  = cnt_q[3:2];
    n     = $signed(pln_i[axis]);
    pt    = (op_i == fpec_pkg::OP_BOX && n > 0) ? $signed(hi_i[axis]) : $signed(lo_i[axis]);
    nm    = n[47] ? 47'(-n) : n[46:0];
    pm    = pt[31] ? 32'(-pt) : pt;
    neg   = n[47] ^ pt[31];
    mul_a = (cnt_q[1:0] == 2'd0) ? nm[23:0] : {1'b0, nm[46:24]};
    tsh   = t_q >> FRAC;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 4'd12);
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == 4'd12) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      acc_q <= fpec_pkg::ACC_W'($signed(pln_i[3]));
    end else if (busy_q) begin
      if (cnt_q == 4'd12) begin
        pass_q <= !(acc_q < limit_i);
      end else begin
        case (cnt_q[1:0])
          2'd0: prod_q <= mul_a * pm;
          2'd1: begin
            t_q    <= 79'(prod_q);
            prod_q <= mul_a * pm;
          end
          2'd2: t_q <= t_q + (79'(prod_q) << 24);
          default: begin
            if (neg) begin
              acc_q <= acc_q - $signed(fpec_pkg::ACC_W'(tsh));
            end else begin
              acc_q <= acc_q + $signed(fpec_pkg::ACC_W'(tsh));
            end
          end
        endcase
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.pass = pass_q;

endmodule

[rtl/core/frustum_plane_extract_and_cull_core.sv]
// A load of columns 0 to 2 only writes its column into the plane cells; a query tests
// the six planes in turn through the multiplier of the dot-product unit.
// A load of column 3 also normalizes the six planes: per plane a 32-step square root and
// four 65-step divisions, or neither for a plane whose normal has zero length.
// One item is in work at a time; the next can be accepted in the cycle after the result is
// registered. Reset clears the plane storage, the degenerate flag and all control state.
module frustum_plane_extract_and_cull_core #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  column_index_i,
  input  logic [31:0] val_a_i,
  input  logic [31:0] val_b_i,
  input  logic [31:0] val_c_i,
  input  logic [31:0] val_d_i,
  input  logic [31:0] hi_x_i,
  input  logic [31:0] hi_y_i,
  input  logic [31:0] hi_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  op_echo_o,
  output logic        inside_res_o,
  output logic        degenerate_o
);

  localparam int LIM_SH = 32 - COORD_FRAC_BITS;

  // The control sequencer walks the plane ring: the six cells rotate by one
  // place after the head plane has been normalized or tested, so that after
  // six steps every plane sits in its home cell again.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_NORM  = 4'b0010,
    ST_QUERY = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q;
  logic [2:0] pc_q;
  logic       kick_q;
  logic       deg_acc_q;
  logic       deg_q;
  logic       pass_acc_q;
  logic [1:0] op_q;
  fpec_pkg::xyz_t lo_q;
  fpec_pkg::xyz_t hi_q;
  logic signed [fpec_pkg::ACC_W-1:0] limit_q;
  logic       res_inside_q;
  logic       out_valid_q;
  logic [1:0] out_op_q;
  logic       out_inside_q;
  logic       out_deg_q;

  logic accept;
  logic load_en;
  logic rot;
  logic norm_wr;
  logic kick_d;
  logic [31:0] axis_val [3];

  fpec_pkg::raw_vec_t raw_w [fpec_pkg::NPLANES];
  fpec_pkg::pln_vec_t pln_w [fpec_pkg::NPLANES];
  fpec_pkg::pln_vec_t norm_pln;
  fpec_pkg::norm_res_t norm_res;
  fpec_pkg::dot_res_t  dot_res;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_en    = accept && (operation_i == fpec_pkg::OP_LOAD);
  assign norm_wr    = (state_q == ST_NORM) && norm_res.done;
  assign rot        = norm_wr || ((state_q == ST_QUERY) && dot_res.done);

  // A unit is started for the first plane of a query or a column-3 load, and
  // again after each plane but the last.
  assign kick_d = (accept && ((operation_i != fpec_pkg::OP_LOAD) ||
                              (column_index_i == fpec_pkg::LAST_COL))) ||
                  (rot && (pc_q != 3'(fpec_pkg::NPLANES - 1)));

  assign axis_val[0] = val_a_i;
  assign axis_val[1] = val_b_i;
  assign axis_val[2] = val_c_i;

  // Each cell holds one plane; cell k receives from cell k+1 and the last
  // cell closes the ring from the head, taking the fresh normalized plane when one is written.
  for (genvar k = 0; k < fpec_pkg::NPLANES; k++) begin : g_cell
    fpec_pkg::raw_vec_t raw_in;
    fpec_pkg::pln_vec_t pln_in;
    if (k == fpec_pkg::NPLANES - 1) begin : g_tail
      assign raw_in = raw_w[0];
      assign pln_in = norm_wr ? norm_pln : pln_w[0];
    end else begin : g_mid
      assign raw_in = raw_w[k+1];
      assign pln_in = pln_w[k+1];
    end
    fpec_cell #(.PLANE(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (load_en),
      .col_i   (column_index_i),
      .val_x_i (axis_val[k/2]),
      .val_d_i (val_d_i),
      .shift_i (rot),
      .raw_i   (raw_in),
      .pln_i   (pln_in),
      .raw_o   (raw_w[k]),
      .pln_o   (pln_w[k])
    );
  end

  fpec_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (kick_q && (state_q == ST_NORM)),
    .raw_i   (raw_w[0]),
    .pln_o   (norm_pln),
    .res_o   (norm_res)
  );

  fpec_dot #(.FRAC(COORD_FRAC_BITS)) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (kick_q && (state_q == ST_QUERY)),
    .op_i    (op_q),
    .pln_i   (pln_w[0]),
    .lo_i    (lo_q),
    .hi_i    (hi_q),
    .limit_i (limit_q),
    .res_o   (dot_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      kick_q      <= 1'b0;
      deg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      kick_q <= kick_d;
      if ((state_q == ST_DONE) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pc_q <= '0;
            if (operation_i != fpec_pkg::OP_LOAD) begin
              state_q <= ST_QUERY;
            end else if (column_index_i == fpec_pkg::LAST_COL) begin
              state_q <= ST_NORM;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_NORM: begin
          if (norm_res.done) begin
            if (pc_q == 3'(fpec_pkg::NPLANES - 1)) begin
              // The flag is rebuilt from this pass alone.
              deg_q   <= deg_acc_q || norm_res.deg;
              state_q <= ST_DONE;
            end else begin
              pc_q <= pc_q + 3'd1;
            end
          end
        end
        ST_QUERY: begin
          if (dot_res.done) begin
            if (pc_q == 3'(fpec_pkg::NPLANES - 1)) begin
              state_q <= ST_DONE;
            end else begin
              pc_q <= pc_q + 3'd1;
            end
          end
        end
        ST_DONE: begin
          // The output register lets the sequencer move on while a result waits.
          if (!out_valid_q || out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= operation_i;
      lo_q         <= {val_c_i, val_b_i, val_a_i};
      hi_q         <= {hi_z_i, hi_y_i, hi_x_i};
      limit_q      <= (operation_i == fpec_pkg::OP_SPHERE) ?
                      -($signed({{(fpec_pkg::ACC_W-32){val_d_i[31]}}, val_d_i}) <<< LIM_SH) :
                      '0;
      deg_acc_q    <= 1'b0;
      pass_acc_q   <= 1'b1;
      res_inside_q <= 1'b0;
    end
    if (norm_wr) deg_acc_q <= deg_acc_q || norm_res.deg;
    if ((state_q == ST_QUERY) && dot_res.done) begin
      pass_acc_q   <= pass_acc_q && dot_res.pass;
      res_inside_q <= pass_acc_q && dot_res.pass;
    end
    if ((state_q == ST_DONE) && (!out_valid_q || out_ready_i)) begin
      out_op_q     <= op_q;
      out_inside_q <= res_inside_q;
      out_deg_q    <= deg_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign op_echo_o    = out_op_q;
  assign inside_res_o = out_inside_q;
  assign degenerate_o = out_deg_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("sequencer stayed idle after accepting an item");

  a_plane_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= 3'(fpec_pkg::NPLANES - 1))
    else $error("plane counter ran past the last plane");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result item raised outside the done state");

  a_rotate_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot |-> (state_q == ST_NORM || state_q == ST_QUERY))
    else $error("plane ring rotated while not working on an item");

endmodule

[dv/testbench.sv]
module testbench;

  // One input item as the driver presents it.
  typedef struct {
    fpec_pkg::op_e      op;
    logic [1:0]         col;
    logic signed [31:0] a, b, c, d, hx, hy, hz;
  } cull_item_t;

  // One result item as the monitor compares it.
  typedef struct {
    logic [1:0] op;
    logic       in_frustum;
    logic       deg;
  } cull_res_t;

  localparam int FRAC = 16;
  localparam int ONE = 65536;
  localparam longint CYCLE_LIMIT = 3000000;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  operation_i, column_index_i;
  logic [31:0] val_a_i, val_b_i, val_c_i, val_d_i, hi_x_i, hi_y_i, hi_z_i;
  logic        out_valid_o, out_ready_i;
  logic [1:0]  op_echo_o;
  logic        inside_res_o, degenerate_o;

  frustum_plane_extract_and_cull_core #(.COORD_FRAC_BITS(FRAC)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .column_index_i,
    .val_a_i, .val_b_i, .val_c_i, .val_d_i, .hi_x_i, .hi_y_i, .hi_z_i,
    .out_valid_o, .out_ready_i, .op_echo_o, .inside_res_o, .degenerate_o
  );

  cull_item_t pending_items[$];
  cull_res_t  expected_results[$];
  int         mismatch_count = 0;
  longint     cycle_count = 0;

  // Shadow copy of the block state: unnormalized coefficients, Q16.32 planes, flag.
  longint raw_coef[6][4];
  longint plane_q32[6][4];
  bit     degenerate_shadow;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned r = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= r + bitv) begin
        s = s - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Scales each plane to unit normal length; a zero normal clears the plane.
  function automatic void normalize_planes();
    longint unsigned m[4];
    longint unsigned mx, s, len, ip, rem, q;
    bit deg = 0;
    for (int p = 0; p < 6; p++) begin
      for (int i = 0; i < 4; i++) m[i] = magnitude(raw_coef[p][i]);
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      while (mx >= (64'd1 << 31)) begin
        for (int i = 0; i < 4; i++) m[i] >>= 1;
        mx >>= 1;
      end
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      if (s == 0) begin
        for (int i = 0; i < 4; i++) plane_q32[p][i] = 0;
        deg = 1;
      end else begin
        len = int_sqrt(s);
        for (int i = 0; i < 4; i++) begin
          ip = m[i] / len;
          rem = m[i] % len;
          if (ip >= (64'd1 << 15)) q = (64'd1 << 47) - 1;
          else q = (ip << 32) + ((rem << 32) / len);
          plane_q32[p][i] = raw_coef[p][i] < 0 ? -longint'(q) : longint'(q);
        end
      end
    end
    degenerate_shadow = deg;
  endfunction

  // Signed distance of a point from one plane, products truncated toward zero.
  function automatic logic signed [127:0] plane_distance(int p, longint pt[3]);
    logic signed [127:0] acc;
    logic [95:0] t;
    bit neg;
    acc = plane_q32[p][3];
    for (int i = 0; i < 3; i++) begin
      t = ({32'b0, magnitude(plane_q32[p][i])} * {32'b0, magnitude(pt[i])}) >> FRAC;
      neg = (plane_q32[p][i] < 0) != (pt[i] < 0);
      acc = neg ? acc - $signed({32'b0, t}) : acc + $signed({32'b0, t});
    end
    return acc;
  endfunction

  function automatic cull_res_t predict_cull(cull_item_t it);
    cull_res_t r;
    longint lo[3], hi[3], pt[3];
    logic signed [127:0] lim;
    bit pass_all = 1;
    lo = '{longint'(it.a), longint'(it.b), longint'(it.c)};
    hi = '{longint'(it.hx), longint'(it.hy), longint'(it.hz)};
    if (it.op == fpec_pkg::OP_LOAD) begin
      raw_coef[0][it.col] = longint'(it.d) + longint'(it.a);
      raw_coef[1][it.col] = longint'(it.d) - longint'(it.a);
      raw_coef[2][it.col] = longint'(it.d) + longint'(it.b);
      raw_coef[3][it.col] = longint'(it.d) - longint'(it.b);
      raw_coef[4][it.col] = longint'(it.d) + longint'(it.c);
      raw_coef[5][it.col] = longint'(it.d) - longint'(it.c);
      if (it.col == fpec_pkg::LAST_COL) normalize_planes();
      pass_all = 0;
    end else begin
      lim = 0;
      if (it.op == fpec_pkg::OP_SPHERE) lim = -(longint'(it.d) * (longint'(1) << (32 - FRAC)));
      for (int p = 0; p < 6; p++) begin
        for (int i = 0; i < 3; i++)
          pt[i] = (it.op == fpec_pkg::OP_BOX && plane_q32[p][i] > 0) ? hi[i] : lo[i];
        if (plane_distance(p, pt) < lim) pass_all = 0;
      end
    end
    r.op = it.op;
    r.in_frustum = pass_all;
    r.deg = degenerate_shadow;
    return r;
  endfunction

  // ---------------- stimulus ----------------

  function automatic void push_item(fpec_pkg::op_e op, logic [1:0] col, logic [31:0] a,
                                    logic [31:0] b, logic [31:0] c, logic [31:0] d,
                                    logic [31:0] hx = 0, logic [31:0] hy = 0,
                                    logic [31:0] hz = 0);
    cull_item_t it;
    it.op = op; it.col = col;
    it.a = a; it.b = b; it.c = c; it.d = d;
    it.hx = hx; it.hy = hy; it.hz = hz;
    pending_items.push_back(it);
  endfunction

  // A coordinate: mostly near the unit cube, sometimes any 32-bit value.
  function automatic logic [31:0] rand_coord(int style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 8 * ONE) - 4 * ONE;
      default: return $urandom_range(0, 3 * ONE) - ONE - ONE / 2;
    endcase
  endfunction

  function automatic void push_matrix_column(int style, logic [1:0] col);
    logic [31:0] v[4];
    for (int r = 0; r < 4; r++) begin
      case (style)
        0: v[r] = $urandom;
        1: v[r] = $urandom_range(0, 8 * ONE) - 4 * ONE;
        2: v[r] = (r == 3 || col == 3) ? rand_coord(1) : 32'd0;
        default: v[r] = (r == col) ? $urandom_range(ONE / 4, 4 * ONE) :
                        ($urandom_range(0, 3) == 0 ? rand_coord(2) / 8 : 32'd0);
      endcase
    end
    push_item(fpec_pkg::OP_LOAD, col, v[0], v[1], v[2], v[3]);
  endfunction

  function automatic void push_query(int style);
    fpec_pkg::op_e op = fpec_pkg::op_e'($urandom_range(1, 3));
    logic [31:0] lo[3], ext[3], rad;
    for (int i = 0; i < 3; i++) begin
      lo[i] = rand_coord(style);
      ext[i] = (style == 0) ? $urandom : lo[i] + $urandom_range(0, ONE);
    end
    rad = (style == 0) ? $urandom : $urandom_range(0, 2 * ONE) - ONE / 4;
    push_item(op, 2'($urandom), lo[0], lo[1], lo[2], rad, ext[0], ext[1], ext[2]);
  endfunction

  initial begin
    int matrix_style, qstyle, nq;
    // Queries before any normalization see zero planes.
    push_item(fpec_pkg::OP_POINT, 2'd0, 32'h7fffffff, 32'h80000000, 0, 0);
    push_item(fpec_pkg::OP_SPHERE, 2'd3, 0, 0, 0, 32'h80000000);
    push_item(fpec_pkg::OP_BOX, 2'd1, 32'h80000000, 0, 0, 0, 32'h7fffffff, 0, 0);
    // Identity view-projection: the frustum is the cube [-1, 1].
    for (int col = 0; col < 4; col++)
      push_item(fpec_pkg::OP_LOAD, 2'(col), col == 0 ? ONE : 0, col == 1 ? ONE : 0,
                col == 2 ? ONE : 0, col == 3 ? ONE : 0);
    push_item(fpec_pkg::OP_POINT, 2'd0, 0, 0, 0, 0);
    push_item(fpec_pkg::OP_POINT, 2'd0, 2 * ONE, 0, 0, 0);
    push_item(fpec_pkg::OP_POINT, 2'd0, ONE, -ONE, ONE, 0);
    push_item(fpec_pkg::OP_POINT, 2'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
    push_item(fpec_pkg::OP_SPHERE, 2'd0, 2 * ONE, 0, 0, ONE + 1);
    push_item(fpec_pkg::OP_SPHERE, 2'd0, 2 * ONE, 0, 0, ONE / 2);
    push_item(fpec_pkg::OP_SPHERE, 2'd0, 0, 0, 0, -ONE / 2);
    push_item(fpec_pkg::OP_SPHERE, 2'd0, 0, 0, 0, 32'h7fffffff);
    push_item(fpec_pkg::OP_BOX, 2'd0, -3 * ONE, -3 * ONE, -3 * ONE, 0,
              3 * ONE, 3 * ONE, 3 * ONE);
    push_item(fpec_pkg::OP_BOX, 2'd0, 2 * ONE, 0, 0, 0, 3 * ONE, ONE, ONE);
    push_item(fpec_pkg::OP_BOX, 2'd0, ONE, ONE, ONE, 0, -ONE, -ONE, -ONE);
    // Extreme columns drive the pre-normalization halving and saturation.
    push_item(fpec_pkg::OP_LOAD, 2'd0, 32'h80000000, 32'h7fffffff, 0, 32'h7fffffff);
    push_item(fpec_pkg::OP_LOAD, 2'd3, 32'h7fffffff, 32'h80000000, 32'h80000000,
              32'h80000000);
    push_item(fpec_pkg::OP_POINT, 2'd0, ONE, ONE, ONE, 0);
    // All-zero normals raise the degenerate flag.
    for (int col = 0; col < 4; col++)
      push_item(fpec_pkg::OP_LOAD, 2'(col), 0, 0, 0, col == 3 ? ONE : 0);
    push_item(fpec_pkg::OP_SPHERE, 2'd0, ONE, 0, 0, ONE);

    while (pending_items.size() < 1400) begin
      matrix_style = $urandom_range(0, 9);
      matrix_style = matrix_style < 1 ? 0 : matrix_style < 3 ? 1 : matrix_style < 4 ? 2 : 3;
      if ($urandom_range(0, 7) == 0) begin
        // Partial or out-of-order load that may mix in stale coefficients.
        repeat ($urandom_range(1, 3)) push_matrix_column(matrix_style, 2'($urandom));
        if ($urandom_range(0, 1)) push_matrix_column(matrix_style, fpec_pkg::LAST_COL);
      end else begin
        for (int col = 0; col < 4; col++) push_matrix_column(matrix_style, 2'(col));
      end
      nq = $urandom_range(8, 24);
      repeat (nq) begin
        qstyle = $urandom_range(0, 9);
        push_query(qstyle == 0 ? 0 : qstyle < 4 ? 1 : 2);
      end
    end
  end

  // ---------------- driver ----------------

  cull_item_t drive_item;
  int         send_gap;
  bit         send_burst;

  assign operation_i    = drive_item.op;
  assign column_index_i = drive_item.col;
  assign val_a_i        = drive_item.a;
  assign val_b_i        = drive_item.b;
  assign val_c_i        = drive_item.c;
  assign val_d_i        = drive_item.d;
  assign hi_x_i         = drive_item.hx;
  assign hi_y_i         = drive_item.hy;
  assign hi_z_i         = drive_item.hz;

  initial begin
    drive_item = '{op: fpec_pkg::OP_LOAD, col: 2'd0, a: 0, b: 0, c: 0, d: 0,
                   hx: 0, hy: 0, hz: 0};
    in_valid_i = 1'b0;
    send_gap = 0;
    send_burst = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    bit free;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      free = !in_valid_i || in_ready_o;
      if (in_valid_i && in_ready_o)
        expected_results.push_back(predict_cull(drive_item));
      if (free) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_items.size() > 0) begin
          drive_item <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 31) == 0) send_burst <= !send_burst;
          send_gap <= send_burst ? 0 : $urandom_range(0, 9);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  int  recv_stall;
  bit  recv_burst;

  initial begin
    out_ready_i = 1'b0;
    recv_stall = 0;
    recv_burst = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    cull_res_t want;
    int stall;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_stall <= 0;
    end else begin
      stall = recv_stall;
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Result with nothing expected: op %0d inside %0b degenerate %0b",
                     op_echo_o, inside_res_o, degenerate_o);
        end else begin
          want = expected_results.pop_front();
          if (op_echo_o !== want.op || inside_res_o !== want.in_frustum ||
              degenerate_o !== want.deg) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected op %0d inside %0b degenerate %0b, got %0d %0b %0b",
                       want.op, want.in_frustum, want.deg, op_echo_o, inside_res_o,
                       degenerate_o);
          end
        end
        if ($urandom_range(0, 31) == 0) recv_burst <= !recv_burst;
        stall = recv_burst ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        recv_stall <= stall - 1;
      end else begin
        out_ready_i <= 1'b1;
        recv_stall <= 0;
      end
    end
  end

  // ---------------- end of run ----------------

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    // A trailing column-3 load is the slowest item; let any stray result show.
    repeat (2500) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
